// File: sv/mbss_pkg.sv
// Shared types, constants and the byte compare for the masked byte signature search.
package mbss_pkg;

    localparam int SIG_LANES  = 16;
    localparam int SEL_W      = $clog2(SIG_LANES);
    localparam int LEN_W      = 5;
    localparam int HIT_OFF_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN     = 3'd4;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic [HIT_OFF_W-1:0] hit_offset;
        logic                 region_done;
        logic                 found;
    } t_out;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    // A bit takes part in the compare only where its care bit is set.
    function automatic logic lane_match(t_byte b, t_byte p, t_byte m);
        return ((b ^ p) & m) == 8'h00;
    endfunction

endpackage

// File: sv/mbss_cell.sv
// One window cell: holds a byte of the window, compares its input byte with its signature lane.
module mbss_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbss_pkg::t_cell_ctrl i_ctrl,
    input  mbss_pkg::t_byte    i_byte,
    input  mbss_pkg::t_byte    i_sig,
    input  mbss_pkg::t_byte    i_care,
    input  logic               i_lane_en,
    output mbss_pkg::t_byte    o_byte,
    output logic               o_match
);
    import mbss_pkg::*;

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctrl.clear) begin
            r_byte <= '0;
        end else if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    // a lane beyond the signature length always passes
    assign o_match = !i_lane_en || lane_match(i_byte, i_sig, i_care);

endmodule

// File: sv/masked_byte_signature_search.sv
// Masked byte signature search: top level with configuration, window chain and output buffer.
//
// Feed the bytes of a region on the input channel, one transfer per byte, with region_end
// set on the last byte. Every accepted byte gives exactly one result transfer: hit marks
// the byte where the region's first match completes, hit_offset holds that match's window
// start (0 until a match), found tells whether a match was seen so far, and region_done
// echoes region_end. After the last byte the window, byte counter and match state clear.
// Program the signature, care bits and length through the write port (index 0..4) while
// no byte is in flight; indexes past the list are dropped.
// A byte's result goes into the result register, or into the skid entry if that is full.
// One byte per cycle while o_in_stall is low; the row of window cells compares combinationally.
// The output side has a result register plus one skid entry; when the receiver stalls,
// the block takes one more byte and then raises o_in_stall until the skid entry drains.
// Reset (synchronous, active low) empties the buffer, clears the region state and loads
// the configuration defaults (length 1, everything else zero); no clearing pass follows.
module masked_byte_signature_search #(
    parameter int MAX_SIG_BYTES = 16,
    parameter int OFFSET_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbss_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbss_pkg::t_out                    o_out_data
);
    import mbss_pkg::*;

    localparam int SigLimit = (MAX_SIG_BYTES < SIG_LANES) ? MAX_SIG_BYTES : SIG_LANES;

    // configuration
    logic [CFG_DATA_W-1:0] r_sig_lo;
    logic [CFG_DATA_W-1:0] r_sig_hi;
    logic [CFG_DATA_W-1:0] r_care_lo;
    logic [CFG_DATA_W-1:0] r_care_hi;
    logic [LEN_W-1:0]      r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_lo  <= '0;
            r_sig_hi  <= '0;
            r_care_lo <= '0;
            r_care_hi <= '0;
            r_len     <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIG_LO:  r_sig_lo  <= i_cfg_data;
                CFG_SIG_HI:  r_sig_hi  <= i_cfg_data;
                CFG_CARE_LO: r_care_lo <= i_cfg_data;
                CFG_CARE_HI: r_care_hi <= i_cfg_data;
                CFG_LEN:     r_len     <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] w_len;
    t_byte            w_sig_lane  [SIG_LANES];
    t_byte            w_care_lane [SIG_LANES];

    always_comb begin
        w_len = r_len;
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(SigLimit)) begin
            w_len = LEN_W'(SigLimit);
        end
    end

    always_comb begin
        for (int l = 0; l < SIG_LANES / 2; l++) begin
            w_sig_lane[l]                  = r_sig_lo[8*l +: 8];
            w_sig_lane[l + SIG_LANES / 2]  = r_sig_hi[8*l +: 8];
            w_care_lane[l]                 = r_care_lo[8*l +: 8];
            w_care_lane[l + SIG_LANES / 2] = r_care_hi[8*l +: 8];
        end
    end

    // region state
    logic [OFFSET_BITS-1:0] r_count;
    logic                   r_seen;
    logic [OFFSET_BITS-1:0] r_off;

    logic       w_acc;
    t_cell_ctrl w_ctrl;

    assign w_acc        = i_in_valid && !o_in_stall;
    assign w_ctrl.shift = w_acc && !i_in_data.region_end;
    assign w_ctrl.clear = w_acc && i_in_data.region_end;

    // window chain: lane 0 sees the incoming byte, lane q the byte q steps back
    t_byte                    w_node [MAX_SIG_BYTES];
    logic [MAX_SIG_BYTES-1:0] w_lane_ok;

    assign w_node[0] = i_in_data.data_byte;

    for (genvar q = 0; q < MAX_SIG_BYTES; q++) begin : g_lane
        t_byte w_sig;
        t_byte w_care;
        logic  w_en;

        if (q < SigLimit) begin : g_used
            logic [LEN_W-1:0] w_sel;
            // lane q lines up with signature byte len-1-q
            assign w_sel  = w_len - LEN_W'(q + 1);
            assign w_en   = w_len > LEN_W'(q);
            assign w_sig  = w_sig_lane[w_sel[SEL_W-1:0]];
            assign w_care = w_care_lane[w_sel[SEL_W-1:0]];
        end else begin : g_unused
            assign w_en   = 1'b0;
            assign w_sig  = '0;
            assign w_care = '0;
        end

        if (q < MAX_SIG_BYTES - 1) begin : g_cell
            mbss_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_byte    (w_node[q]),
                .i_sig     (w_sig),
                .i_care    (w_care),
                .i_lane_en (w_en),
                .o_byte    (w_node[q+1]),
                .o_match   (w_lane_ok[q])
            );
        end else begin : g_tail
            // oldest lane has no successor to feed
            assign w_lane_ok[q] = !w_en || lane_match(w_node[q], w_sig, w_care);
        end
    end

    logic [OFFSET_BITS-1:0] w_len_m1;
    logic                   w_count_ok;
    logic                   w_hit;
    logic                   w_seen;
    logic [OFFSET_BITS-1:0] w_off;
    t_out                   w_res;

    assign w_len_m1   = OFFSET_BITS'(w_len) - OFFSET_BITS'(1);
    assign w_count_ok = r_count >= w_len_m1;
    assign w_hit      = (&w_lane_ok) && w_count_ok && !r_seen;
    assign w_seen     = r_seen || w_hit;
    assign w_off      = w_hit ? (r_count - w_len_m1) : r_off;

    assign w_res.hit         = w_hit;
    assign w_res.hit_offset  = HIT_OFF_W'(w_off);
    assign w_res.region_done = i_in_data.region_end;
    assign w_res.found       = w_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seen  <= 1'b0;
            r_off   <= '0;
        end else if (w_acc) begin
            if (i_in_data.region_end) begin
                r_count <= '0;
                r_seen  <= 1'b0;
                r_off   <= '0;
            end else begin
                // saturate the byte index
                if (r_count != '1) begin
                    r_count <= r_count + OFFSET_BITS'(1);
                end
                r_seen <= w_seen;
                r_off  <= w_off;
            end
        end
    end

    // output register plus skid entry
    logic r_ov;
    logic r_sv;
    t_out r_out;
    t_out r_skid;
    logic w_take;
    logic w_room;

    assign w_take = r_ov && !i_out_stall;
    assign w_room = w_take || !r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv && w_room) begin
            r_ov <= 1'b1;
            r_sv <= 1'b0;
        end else if (w_acc && w_room) begin
            r_ov <= 1'b1;
        end else if (w_acc) begin
            r_sv <= 1'b1;
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv && w_room) begin
            r_out <= r_skid;
        end else if (w_acc && w_room) begin
            r_out <= w_res;
        end else if (w_acc) begin
            r_skid <= w_res;
        end
    end

    assign o_in_stall  = r_sv;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry holds a result while the output register is empty");

    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hit) |-> o_out_data.found)
        else $error("hit reported without found");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_data.region_end) |=> (r_count == '0 && !r_seen && r_off == '0))
        else $error("region state not cleared after the last byte");

    a_off_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_off == '0))
        else $error("match offset set while no match seen");

endmodule

// File: tb/masked_byte_signature_search_test.sv
// Self-checking testbench for the masked byte signature search block.
`timescale 1ns / 100ps

module masked_byte_signature_search_test;
    import mbss_pkg::*;

    localparam int  RUN_LIMIT_NS  = 20_000_000;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  BYTE_TARGET   = 1500;
    localparam int  IDLE_PERCENT  = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_LEN + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;

    masked_byte_signature_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Signature setup as the block should hold it
    logic [63:0]      sig_lo_reg;
    logic [63:0]      sig_hi_reg;
    logic [63:0]      care_lo_reg;
    logic [63:0]      care_hi_reg;
    logic [LEN_W-1:0] len_reg;

    // Region scan state
    logic [7:0]           recent_bytes [SIG_LANES-1];
    logic [31:0]          bytes_in_region;
    logic                 first_hit_seen;
    logic [HIT_OFF_W-1:0] first_hit_offset;

    t_out owed_reports [$];
    bit   idle_on;
    int   errors;
    int   bytes_sent;
    int   regions_sent;
    int   hits_predicted;
    int   cfg_setups;

    function automatic int active_length();
        int n;
        n = len_reg;
        if (n == 0) n = 1;
        if (n > SIG_LANES) n = SIG_LANES;
        return n;
    endfunction

    function automatic void clear_region();
        foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
        bytes_in_region  = '0;
        first_hit_seen   = 1'b0;
        first_hit_offset = '0;
    endfunction

    // Advance the scan by one byte and return the report it must produce.
    function automatic t_out scan_byte(logic [7:0] b, logic last);
        t_out         r;
        int           n;
        bit           ok;
        logic [127:0] sig_all;
        logic [127:0] care_all;
        logic [7:0]   w;
        n        = active_length();
        sig_all  = {sig_hi_reg, sig_lo_reg};
        care_all = {care_hi_reg, care_lo_reg};
        r        = '0;
        if ({32'd0, bytes_in_region} + 64'd1 >= 64'(n)) begin
            ok = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (i == n - 1) w = b;
                else            w = recent_bytes[n - 2 - i];
                if (((w ^ sig_all[8*i +: 8]) & care_all[8*i +: 8]) != 8'h00) ok = 1'b0;
            end
            if (ok && !first_hit_seen) begin
                r.hit            = 1'b1;
                first_hit_seen   = 1'b1;
                first_hit_offset = bytes_in_region + 32'd1 - 32'(n);
                hits_predicted++;
            end
        end
        r.hit_offset  = first_hit_seen ? first_hit_offset : '0;
        r.region_done = last;
        r.found       = first_hit_seen;
        if (last) begin
            clear_region();
        end else begin
            for (int k = SIG_LANES - 2; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
            recent_bytes[0] = b;
            if (bytes_in_region != 32'hFFFF_FFFF) bytes_in_region++;
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else          i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge i_clk) begin : check_reports
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_reports.size() == 0) begin
                $error("result transfer with nothing outstanding: %p", o_out_data);
                errors++;
            end else begin
                want = owed_reports.pop_front();
                if (o_out_data.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_out_data.hit);
                    errors++;
                end
                if (o_out_data.hit_offset !== want.hit_offset) begin
                    $error("hit_offset: expected %0d, got %0d",
                           want.hit_offset, o_out_data.hit_offset);
                    errors++;
                end
                if (o_out_data.region_done !== want.region_done) begin
                    $error("region_done: expected %0d, got %0d",
                           want.region_done, o_out_data.region_done);
                    errors++;
                end
                if (o_out_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_out_data.found);
                    errors++;
                end
            end
        end
    end

    // Offer one byte; return at the edge where it transfers.
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in item;
        item.data_byte  = b;
        item.region_end = last;
        @(negedge i_clk);
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        owed_reports.push_back(scan_byte(b, last));
        bytes_sent++;
        if (last) regions_sent++;
    endtask

    task automatic send_region(input logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    // Drop valid and wait until every report is back and the block is quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        case (idx)
            CFG_SIG_LO:  sig_lo_reg  = val;
            CFG_SIG_HI:  sig_hi_reg  = val;
            CFG_CARE_LO: care_lo_reg = val;
            CFG_CARE_HI: care_hi_reg = val;
            CFG_LEN:     len_reg     = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_signature(input logic [63:0] sig_lo, input logic [63:0] sig_hi,
                                  input logic [63:0] care_lo, input logic [63:0] care_hi,
                                  input logic [63:0] len);
        cfg_write(CFG_SIG_LO, sig_lo);
        cfg_write(CFG_SIG_HI, sig_hi);
        cfg_write(CFG_CARE_LO, care_lo);
        cfg_write(CFG_CARE_HI, care_hi);
        cfg_write(CFG_LEN, len);
        cfg_close();
        cfg_setups++;
    endtask

    // Write a matching copy of the signature at the given offset, don't-care bits random; spoil flips one cared bit.
    function automatic void plant_signature(ref logic [7:0] q[$], input int at, input bit spoil);
        logic [127:0] sig_all;
        logic [127:0] care_all;
        logic [7:0]   c;
        int           n;
        int           lane;
        int           bitpos;
        n        = active_length();
        sig_all  = {sig_hi_reg, sig_lo_reg};
        care_all = {care_hi_reg, care_lo_reg};
        for (int i = 0; i < n; i++) begin
            c         = care_all[8*i +: 8];
            q[at + i] = (sig_all[8*i +: 8] & c) | (8'($urandom) & ~c);
        end
        if (spoil) begin
            lane = $urandom_range(0, n - 1);
            c    = care_all[8*lane +: 8];
            if (c != 8'h00) begin
                do bitpos = $urandom_range(0, 7); while (!c[bitpos]);
                q[at + lane] = q[at + lane] ^ (8'h01 << bitpos);
            end
        end
    endfunction

    function automatic logic [63:0] random_care();
        case ($urandom_range(0, 4))
            0:       return '1;
            1:       return '0;
            2:       return {$urandom, $urandom} & 64'hF0F0_0F0F_FF00_00FF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_setup(input int pick);
        logic [63:0] len;
        len = {$urandom, $urandom};
        case (pick)
            0: begin
                len[LEN_W-1:0] = 5'd16;
                load_signature('1, '1, '1, '1, len);
            end
            1: begin
                len[LEN_W-1:0] = 5'd31;
                load_signature('0, '0, '1, '1, len);
            end
            2: begin
                len[LEN_W-1:0] = 5'd0;
                load_signature({$urandom, $urandom}, {$urandom, $urandom}, '1, '1, len);
            end
            default: begin
                if ($urandom_range(0, 5) == 0) len[LEN_W-1:0] = 5'($urandom_range(17, 31));
                else                           len[LEN_W-1:0] = 5'($urandom_range(1, 16));
                load_signature({$urandom, $urandom}, {$urandom, $urandom},
                               random_care(), random_care(), len);
            end
        endcase
        // Writes past the register list must leave the setup untouched.
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                      {$urandom, $urandom});
            cfg_close();
        end
    endtask

    task automatic random_region();
        logic [7:0] q[$];
        int         n;
        int         len;
        int         shape;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(25, 64);
        else                           n = $urandom_range(1, 24);
        len = active_length();
        for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        shape = $urandom_range(0, 9);
        if (n >= len && shape < 8) begin
            plant_signature(q, $urandom_range(0, n - len), shape == 0);
            if (shape == 1) plant_signature(q, $urandom_range(0, n - len), 1'b0);
            if (shape == 2) plant_signature(q, n - len, 1'b0);
        end
        send_region(q);
    endtask

    task automatic test_reset_defaults();
        // Length 1 with nothing cared for matches the first byte of every region.
        send_region('{8'h00, 8'hFF});
        send_region('{8'hA5});
        settle();
    endtask

    task automatic test_exact_signature();
        load_signature(64'h0000_0000_0033_2211, '0, 64'h0000_0000_00FF_FFFF, '0, 64'd3);
        send_region('{8'h11, 8'h22});
        send_region('{8'h00, 8'h11, 8'h22, 8'h33, 8'h11, 8'h22, 8'h33});
        send_region('{8'h44, 8'h11, 8'h22, 8'h33});
        settle();
    endtask

    task automatic test_masked_bits();
        load_signature(64'h0000_0000_0000_0AF0, '0, 64'h0000_0000_0000_0FF0, '0, 64'd2);
        send_region('{8'hFF, 8'h3A});
        settle();
    endtask

    task automatic test_length_folding();
        // Only the low length bits count; zero acts as one.
        load_signature(64'h80, '0, 64'h80, '0, 64'hFFFF_FFFF_FFFF_FFE0);
        for (int k = CFG_UNUSED_FIRST; k <= CFG_UNUSED_LAST; k++)
            cfg_write(CFG_IDX_W'(k), '1);
        cfg_close();
        send_region('{8'h7F, 8'h80});
        settle();
    endtask

    task automatic test_no_idle_stretch();
        int stop_at;
        idle_on = 1'b0;
        random_setup(3);
        stop_at = bytes_sent + 200;
        while (bytes_sent < stop_at) random_region();
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_scan();
        int pick;
        pick = 0;
        while (bytes_sent < BYTE_TARGET) begin
            random_setup(pick);
            repeat ($urandom_range(3, 8)) random_region();
            settle();
            pick++;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        idle_on     = 1'b1;
        sig_lo_reg  = '0;
        sig_hi_reg  = '0;
        care_lo_reg = '0;
        care_hi_reg = '0;
        len_reg     = 5'd1;
        clear_region();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_exact_signature();
        test_masked_bits();
        test_length_folding();
        test_no_idle_stretch();
        test_random_scan();
        settle();

        $display("Scanned %0d bytes in %0d regions under %0d signature setups.",
                 bytes_sent, regions_sent, cfg_setups);
        $display("First matches predicted: %0d; mismatches: %0d.", hits_predicted, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Timed out with %0d reports outstanding.", owed_reports.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
